FILE: rtl/swrr_pkg.sv
// Shared types and constants for the sliding-window reorder receiver.
package swrr_pkg;

   localparam int SEQ_W     = 32;
   localparam int FLG_W     = 8;
   localparam int REF_W     = 16;
   localparam int LEN_W     = 11;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SYN_CODE     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_CODE     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYN_ACK_CODE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIN_MASK     = 4'd3;

   localparam logic [FLG_W-1:0] SYN_CODE_RST     = 8'd1;
   localparam logic [FLG_W-1:0] ACK_CODE_RST     = 8'd2;
   localparam logic [FLG_W-1:0] SYN_ACK_CODE_RST = 8'd3;
   localparam logic [FLG_W-1:0] FIN_MASK_RST     = 8'd4;

   typedef enum logic [KIND_W-1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_SYN_ACK = 2'd2,
      KIND_ABORT   = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PH_WAIT_SYN  = 5'b00001,
      PH_WAIT_ACK  = 5'b00010,
      PH_CONNECTED = 5'b00100,
      PH_CLOSED    = 5'b01000,
      PH_ABORTED   = 5'b10000
   } phase_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EVAL  = 6'b000010,
      ST_STORE = 6'b000100,
      ST_RDREQ = 6'b001000,
      ST_DELIV = 6'b010000,
      ST_ACK   = 6'b100000
   } state_type;

   typedef struct packed {
      logic wr;
      logic clr;
   } slot_op_type;

endpackage

FILE: rtl/swrr_alu.sv
// Shared sequence-number unit: 33-bit difference and a muxed incrementer.
module swrr_alu (
   input  logic [swrr_pkg::SEQ_W-1:0] seq_a,
   input  logic [swrr_pkg::SEQ_W-1:0] exp_b,
   input  logic                       inc_sel_seq,
   output logic [swrr_pkg::SEQ_W:0]   diff,
   output logic [swrr_pkg::SEQ_W-1:0] inc
);
   import swrr_pkg::*;

   logic [SEQ_W-1:0] inc_op;

   assign diff   = {1'b0, seq_a} - {1'b0, exp_b};
   assign inc_op = inc_sel_seq ? seq_a : exp_b;
   assign inc    = inc_op + SEQ_W'(1);

endmodule

FILE: rtl/swrr_slots.sv
// Slot table: valid flags in flops, descriptors in a registered-read memory.
module swrr_slots #(
   parameter int WINDOW = 16,
   parameter int IDX_W  = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  swrr_pkg::slot_op_type      op,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [swrr_pkg::REF_W-1:0] wr_ref,
   input  logic [swrr_pkg::LEN_W-1:0] wr_len,
   input  logic                       wr_fin,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic                       wr_vld,
   output logic                       rd_vld,
   output logic [swrr_pkg::REF_W-1:0] rd_ref,
   output logic [swrr_pkg::LEN_W-1:0] rd_len,
   output logic                       rd_fin
);
   import swrr_pkg::*;

   localparam int ENT_W = REF_W + LEN_W + 1;

   logic [WINDOW-1:0] valid_ff;
   logic [ENT_W-1:0]  mem [WINDOW];
   logic [ENT_W-1:0]  rd_q_ff;

   assign wr_vld = valid_ff[wr_addr];
   assign rd_vld = valid_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (op.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (op.clr) begin
            valid_ff[rd_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op.wr) begin
         mem[wr_addr] <= {wr_fin, wr_len, wr_ref};
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign rd_ref = rd_q_ff[REF_W-1:0];
   assign rd_len = rd_q_ff[REF_W+LEN_W-1:REF_W];
   assign rd_fin = rd_q_ff[ENT_W-1];

endmodule

FILE: rtl/sliding_window_reorder_receiver_top.sv
// Top level: handshake, window check and in-order release sequencer.
//
// Usage:
//   Request channel: drive req_* with start high; the request is taken at an
//   edge where busy is low. busy stays high until the request is finished.
//   Results appear on rsp_* for one cycle each, marked by rsp_valid; the
//   receiver cannot stall them. rsp_last marks the final result of a request.
//   CSR channel: csr_index/csr_wdata taken when csr_valid and csr_ready are
//   high; csr_ready is high while the block is idle. Unknown indexes ignored.
//   Sequencer states per request (busy states after the accept edge):
//     handshake, old, closed or out-of-window request: evaluate state only; the
//     result (if any) on the following cycle.
//     in-window request: evaluate, store, then per released packet a slot-memory
//     read and a delivery on the single sequence incrementer, then a final read
//     and the ack; the final read is skipped when the release ends at a FIN or
//     the last sequence number. Each result shows in the cycle after its state.
//   Reset: link returns to waiting for SYN at sequence 0, slots emptied,
//   CSRs return to their defaults. No clearing pass is needed.
module sliding_window_reorder_receiver_top #(
   parameter int WINDOW      = 16,
   parameter int PAYLOAD_MAX = 1024,
   parameter int REF_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [swrr_pkg::SEQ_W-1:0]     req_seq_no,
   input  logic [swrr_pkg::FLG_W-1:0]     req_flags,
   input  logic [swrr_pkg::REF_W-1:0]     req_payload_ref,
   input  logic [swrr_pkg::LEN_W-1:0]     req_payload_len,
   output logic                           rsp_valid,
   output logic [swrr_pkg::KIND_W-1:0]    rsp_kind,
   output logic [swrr_pkg::SEQ_W-1:0]     rsp_seq_no_out,
   output logic [swrr_pkg::FLG_W-1:0]     rsp_flags_out,
   output logic [swrr_pkg::REF_W-1:0]     rsp_payload_ref_out,
   output logic [swrr_pkg::LEN_W-1:0]     rsp_payload_len_out,
   output logic                           rsp_is_fin,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [swrr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swrr_pkg::FLG_W-1:0]     csr_wdata
);
   import swrr_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [15:0] PMAX = 16'(PAYLOAD_MAX);
   localparam logic [REF_W-1:0] REF_MASK =
      (REF_BITS >= REF_W) ? {REF_W{1'b1}} : REF_W'((64'd1 << REF_BITS) - 64'd1);
   localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(WINDOW - 1);
   localparam logic [IDX_W:0]   WIN_SUM   = (IDX_W + 1)'(WINDOW);
   localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(WINDOW);
   localparam logic [SEQ_W-1:0] WIN_SEQ   = SEQ_W'(WINDOW);

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [SEQ_W-1:0] exp_ff, exp_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] off_ff, off_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [FLG_W-1:0] flg_ff, flg_in;
   logic [REF_W-1:0] ref_ff, ref_in;
   logic [LEN_W-1:0] len_ff, len_in;

   logic [FLG_W-1:0] syn_code_ff, ack_code_ff, syn_ack_code_ff, fin_mask_ff;

   logic             rsp_valid_ff;
   kind_type         rsp_kind_ff;
   logic [SEQ_W-1:0] rsp_seq_ff;
   logic [FLG_W-1:0] rsp_flg_ff;
   logic [REF_W-1:0] rsp_ref_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic             rsp_fin_ff;
   logic             rsp_last_ff;

   logic             out_fire;
   kind_type         out_kind;
   logic [SEQ_W-1:0] out_seq;
   logic [FLG_W-1:0] out_flg;
   logic [REF_W-1:0] out_ref;
   logic [LEN_W-1:0] out_len;
   logic             out_fin;
   logic             out_last;

   logic [SEQ_W:0]   diff;
   logic [SEQ_W-1:0] inc;
   logic             inc_sel_seq;
   logic             in_win;
   logic [FLG_W-1:0] want;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W:0]   slot_sum;
   logic [IDX_W-1:0] slot_idx;
   logic [LEN_W-1:0] len_sat;

   slot_op_type      slot_op;
   logic             wr_vld, rd_vld;
   logic [REF_W-1:0] rd_ref;
   logic [LEN_W-1:0] rd_len;
   logic             rd_fin;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   assign inc_sel_seq = (state_ff == ST_EVAL) && (phase_ff == PH_CONNECTED);

   swrr_alu u_alu (
      .seq_a       (seq_ff),
      .exp_b       (exp_ff),
      .inc_sel_seq (inc_sel_seq),
      .diff        (diff),
      .inc         (inc)
   );

   assign in_win    = !diff[SEQ_W] && (diff[SEQ_W-1:0] < WIN_SEQ);
   assign want      = (phase_ff == PH_WAIT_SYN) ? syn_code_ff : ack_code_ff;
   assign head_next = (head_ff == HEAD_LAST) ? '0 : head_ff + IDX_W'(1);
   assign slot_sum  = {1'b0, head_ff} + {1'b0, off_ff};
   assign slot_idx  = (slot_sum >= WIN_SUM) ? IDX_W'(slot_sum - WIN_SUM)
                                            : slot_sum[IDX_W-1:0];
   assign len_sat   = ({5'b0, req_payload_len} > PMAX) ? PMAX[LEN_W-1:0]
                                                       : req_payload_len;

   swrr_slots #(
      .WINDOW (WINDOW),
      .IDX_W  (IDX_W)
   ) u_slots (
      .clock   (clock),
      .reset   (reset),
      .op      (slot_op),
      .wr_addr (slot_idx),
      .wr_ref  (ref_ff),
      .wr_len  (len_ff),
      .wr_fin  ((flg_ff & fin_mask_ff) != '0),
      .rd_addr (head_ff),
      .wr_vld  (wr_vld),
      .rd_vld  (rd_vld),
      .rd_ref  (rd_ref),
      .rd_len  (rd_len),
      .rd_fin  (rd_fin)
   );

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      exp_in   = exp_ff;
      head_in  = head_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      seq_in   = seq_ff;
      flg_in   = flg_ff;
      ref_in   = ref_ff;
      len_in   = len_ff;
      out_fire = 1'b0;
      out_kind = KIND_ACK;
      out_seq  = exp_ff;
      out_flg  = '0;
      out_ref  = '0;
      out_len  = '0;
      out_fin  = 1'b0;
      out_last = 1'b1;
      slot_op  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               seq_in   = req_seq_no;
               flg_in   = req_flags;
               ref_in   = req_payload_ref & REF_MASK;
               len_in   = len_sat;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (phase_ff inside {PH_WAIT_SYN, PH_WAIT_ACK}) begin
               if (flg_ff != want || diff != '0) begin
                  out_fire = 1'b1;
                  out_kind = KIND_ABORT;
                  phase_in = PH_ABORTED;
               end else begin
                  exp_in  = inc;
                  head_in = head_next;
                  if (phase_ff == PH_WAIT_SYN) begin
                     out_fire = 1'b1;
                     out_kind = KIND_SYN_ACK;
                     out_seq  = inc;
                     out_flg  = syn_ack_code_ff;
                     phase_in = PH_WAIT_ACK;
                  end else begin
                     phase_in = PH_CONNECTED;
                  end
               end
            end else if (phase_ff == PH_CONNECTED) begin
               if (diff[SEQ_W]) begin
                  out_fire = 1'b1;
                  out_kind = KIND_ACK;
                  out_seq  = inc;
                  out_flg  = ack_code_ff;
               end else if (in_win) begin
                  off_in   = diff[IDX_W-1:0];
                  cnt_in   = '0;
                  state_in = ST_STORE;
               end
            end
         end
         ST_STORE: begin
            slot_op.wr = !wr_vld;
            state_in   = ST_RDREQ;
         end
         ST_RDREQ: begin
            state_in = (rd_vld && cnt_ff < WIN_CNT) ? ST_DELIV : ST_ACK;
         end
         ST_DELIV: begin
            out_fire    = 1'b1;
            out_kind    = KIND_DELIVER;
            out_ref     = rd_ref;
            out_len     = rd_len;
            out_fin     = rd_fin;
            out_last    = 1'b0;
            slot_op.clr = 1'b1;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (exp_ff == '1) begin
               phase_in = PH_CLOSED;
               state_in = ST_ACK;
            end else begin
               exp_in  = inc;
               head_in = head_next;
               if (rd_fin) begin
                  phase_in = PH_CLOSED;
                  state_in = ST_ACK;
               end else begin
                  state_in = ST_RDREQ;
               end
            end
         end
         ST_ACK: begin
            out_fire = 1'b1;
            out_kind = KIND_ACK;
            out_flg  = ack_code_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT_SYN;
         exp_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         exp_ff       <= exp_in;
         head_ff      <= head_in;
         rsp_valid_ff <= out_fire;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      cnt_ff <= cnt_in;
      seq_ff <= seq_in;
      flg_ff <= flg_in;
      ref_ff <= ref_in;
      len_ff <= len_in;
      if (out_fire) begin
         rsp_kind_ff <= out_kind;
         rsp_seq_ff  <= out_seq;
         rsp_flg_ff  <= out_flg;
         rsp_ref_ff  <= out_ref;
         rsp_len_ff  <= out_len;
         rsp_fin_ff  <= out_fin;
         rsp_last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         syn_code_ff     <= SYN_CODE_RST;
         ack_code_ff     <= ACK_CODE_RST;
         syn_ack_code_ff <= SYN_ACK_CODE_RST;
         fin_mask_ff     <= FIN_MASK_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYN_CODE:     syn_code_ff     <= csr_wdata;
            CSR_ACK_CODE:     ack_code_ff     <= csr_wdata;
            CSR_SYN_ACK_CODE: syn_ack_code_ff <= csr_wdata;
            CSR_FIN_MASK:     fin_mask_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_seq_no_out      = rsp_seq_ff;
   assign rsp_flags_out       = rsp_flg_ff;
   assign rsp_payload_ref_out = rsp_ref_ff;
   assign rsp_payload_len_out = rsp_len_ff;
   assign rsp_is_fin          = rsp_fin_ff;
   assign rsp_last            = rsp_last_ff;

   // request completion always lands back in idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last result while sequencer busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_abort_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ABORTED |=> phase_ff == PH_ABORTED)
      else $error("left aborted phase without reset");

   a_deliver_conn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DELIVER |->
         phase_ff == PH_CONNECTED || phase_ff == PH_CLOSED)
      else $error("delivery outside connected link");

endmodule

FILE: sim/tb_sliding_window_reorder_receiver_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window reorder receiver top level.
module tb_sliding_window_reorder_receiver_top;
   import swrr_pkg::*;

   localparam int WINDOW      = 16;
   localparam int PAYLOAD_MAX = 1024;
   localparam int REF_BITS    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 4'hF;
   localparam logic [FLG_W-1:0]     FIN_FLAG   = 8'h01;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
      logic [FLG_W-1:0]  flg;
      logic [REF_W-1:0]  pref;
      logic [LEN_W-1:0]  plen;
      logic              fin;
      logic              last;
   } result_type;

   class link_tracker_type;
      logic [FLG_W-1:0] syn_code, ack_code, syn_ack_code, fin_mask;
      phase_type        phase;
      logic [SEQ_W-1:0] exp_seq;
      logic             slot_valid [WINDOW];
      logic [REF_W-1:0] slot_ref   [WINDOW];
      logic [LEN_W-1:0] slot_len   [WINDOW];
      logic             slot_fin   [WINDOW];
      result_type       due_results [$];
      int               errors;

      function new();
         syn_code     = SYN_CODE_RST;
         ack_code     = ACK_CODE_RST;
         syn_ack_code = SYN_ACK_CODE_RST;
         fin_mask     = FIN_MASK_RST;
         phase        = PH_WAIT_SYN;
         exp_seq      = '0;
         errors       = 0;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [FLG_W-1:0] data);
         case (idx)
            CSR_SYN_CODE:     syn_code = data;
            CSR_ACK_CODE:     ack_code = data;
            CSR_SYN_ACK_CODE: syn_ack_code = data;
            CSR_FIN_MASK:     fin_mask = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void push(kind_type kind, logic [SEQ_W-1:0] seq, logic [FLG_W-1:0] flg,
                         logic [REF_W-1:0] pref, logic [LEN_W-1:0] plen, logic fin,
                         logic last);
         result_type r;
         r.kind = kind;
         r.seq  = seq;
         r.flg  = flg;
         r.pref = pref;
         r.plen = plen;
         r.fin  = fin;
         r.last = last;
         due_results.push_back(r);
      endfunction

      function void take_packet(logic [SEQ_W-1:0] seq, logic [FLG_W-1:0] flg,
                                logic [REF_W-1:0] pref, logic [LEN_W-1:0] plen);
         logic [LEN_W-1:0] len_sat;
         logic [REF_W-1:0] ref_m;
         logic [FLG_W-1:0] want;
         logic [SEQ_W-1:0] ack_no;
         int unsigned      s, n;
         logic             stop, top, fin;
         len_sat = (plen > PAYLOAD_MAX) ? LEN_W'(PAYLOAD_MAX) : plen;
         ref_m   = pref & REF_W'((64'd1 << REF_BITS) - 1);
         case (phase)
            PH_WAIT_SYN, PH_WAIT_ACK: begin
               want = (phase == PH_WAIT_SYN) ? syn_code : ack_code;
               if (flg != want || seq != exp_seq) begin
                  push(KIND_ABORT, exp_seq, '0, '0, '0, 1'b0, 1'b1);
                  phase = PH_ABORTED;
               end else begin
                  exp_seq++;
                  if (phase == PH_WAIT_SYN) begin
                     phase = PH_WAIT_ACK;
                     push(KIND_SYN_ACK, exp_seq, syn_ack_code, '0, '0, 1'b0, 1'b1);
                  end else begin
                     phase = PH_CONNECTED;
                  end
               end
            end
            PH_CONNECTED: begin
               if (seq < exp_seq) begin
                  push(KIND_ACK, seq + 1, ack_code, '0, '0, 1'b0, 1'b1);
               end else if ({1'b0, seq} < {1'b0, exp_seq} + 33'(WINDOW)) begin
                  s = seq % WINDOW;
                  if (!slot_valid[s]) begin
                     slot_valid[s] = 1'b1;
                     slot_ref[s]   = ref_m;
                     slot_len[s]   = len_sat;
                     slot_fin[s]   = (flg & fin_mask) != '0;
                  end
                  n    = 0;
                  stop = 1'b0;
                  top  = 1'b0;
                  while (!stop && n < WINDOW && slot_valid[exp_seq % WINDOW]) begin
                     s   = exp_seq % WINDOW;
                     fin = slot_fin[s];
                     push(KIND_DELIVER, exp_seq, '0, slot_ref[s], slot_len[s], fin, 1'b0);
                     n++;
                     slot_valid[s] = 1'b0;
                     if (exp_seq == '1) begin
                        top   = 1'b1;
                        stop  = 1'b1;
                        phase = PH_CLOSED;
                     end else begin
                        exp_seq++;
                        if (fin) begin
                           stop  = 1'b1;
                           phase = PH_CLOSED;
                        end
                     end
                  end
                  ack_no = top ? '1 : exp_seq;
                  push(KIND_ACK, ack_no, ack_code, '0, '0, 1'b0, 1'b1);
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         if (errors < 100) $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task cmp(string name, logic [31:0] got, logic [31:0] want, logic [SEQ_W-1:0] seq);
         if (got !== want)
            report($sformatf("%s got %h want %h (expected seq %h)", name, got, want, seq));
      endtask

      task check_result(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                        logic [FLG_W-1:0] flg, logic [REF_W-1:0] pref,
                        logic [LEN_W-1:0] plen, logic fin, logic last);
         result_type want;
         if (due_results.size() == 0) begin
            report($sformatf("result with none due: kind %0d seq %h", kind, seq));
         end else begin
            want = due_results.pop_front();
            cmp("kind", kind, want.kind, want.seq);
            cmp("seq_no_out", seq, want.seq, want.seq);
            cmp("flags_out", flg, want.flg, want.seq);
            cmp("payload_ref_out", pref, want.pref, want.seq);
            cmp("payload_len_out", plen, want.plen, want.seq);
            cmp("is_fin", fin, want.fin, want.seq);
            cmp("last", last, want.last, want.seq);
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [SEQ_W-1:0]     req_seq_no;
   logic [FLG_W-1:0]     req_flags;
   logic [REF_W-1:0]     req_payload_ref;
   logic [LEN_W-1:0]     req_payload_len;
   logic                 rsp_valid;
   logic [KIND_W-1:0]    rsp_kind;
   logic [SEQ_W-1:0]     rsp_seq_no_out;
   logic [FLG_W-1:0]     rsp_flags_out;
   logic [REF_W-1:0]     rsp_payload_ref_out;
   logic [LEN_W-1:0]     rsp_payload_len_out;
   logic                 rsp_is_fin;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FLG_W-1:0]     csr_wdata;

   link_tracker_type link = new();
   int               burst_left = 0;

   sliding_window_reorder_receiver_top #(
      .WINDOW      (WINDOW),
      .PAYLOAD_MAX (PAYLOAD_MAX),
      .REF_BITS    (REF_BITS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_seq_no          (req_seq_no),
      .req_flags           (req_flags),
      .req_payload_ref     (req_payload_ref),
      .req_payload_len     (req_payload_len),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_seq_no_out      (rsp_seq_no_out),
      .rsp_flags_out       (rsp_flags_out),
      .rsp_payload_ref_out (rsp_payload_ref_out),
      .rsp_payload_len_out (rsp_payload_len_out),
      .rsp_is_fin          (rsp_is_fin),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         link.check_result(rsp_kind, rsp_seq_no_out, rsp_flags_out, rsp_payload_ref_out,
                           rsp_payload_len_out, rsp_is_fin, rsp_last);
   end

   // sender runs in bursts; start stays high across back-to-back requests
   task automatic send_request(logic [SEQ_W-1:0] seq, logic [FLG_W-1:0] flg,
                               logic [REF_W-1:0] pref, logic [LEN_W-1:0] plen);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      start           = 1'b1;
      req_seq_no      = seq;
      req_flags       = flg;
      req_payload_ref = pref;
      req_payload_len = plen;
      @(posedge clock);
      while (busy) @(posedge clock);
      link.take_packet(seq, flg, pref, plen);
   endtask

   task automatic send_random(logic [FLG_W-1:0] flag_keep);
      logic [SEQ_W-1:0] e, seq;
      logic [LEN_W-1:0] len;
      int unsigned      pick, back;
      e    = link.exp_seq;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         seq = e + (($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, WINDOW - 1));
      end else if (pick < 78) begin
         back = (e > 40) ? 40 : e - 1;
         seq  = e - 1 - $urandom_range(0, back);
      end else if (pick < 90) begin
         seq = e + WINDOW + $urandom_range(0, 30);
      end else begin
         seq = $urandom;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) len = LEN_W'(PAYLOAD_MAX);
      else if (pick == 1) len = '1;
      else if (pick == 2) len = '0;
      else if (pick < 5) len = LEN_W'($urandom_range(PAYLOAD_MAX + 1, 2047));
      else len = LEN_W'($urandom_range(0, PAYLOAD_MAX));
      send_request(seq, FLG_W'($urandom_range(0, 255)) & flag_keep,
                   REF_W'($urandom_range(0, 65535)), len);
   endtask

   // drain all due results, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      start      = 1'b0;
      burst_left = 0;
      while (link.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [FLG_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      link.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int               fill_order [16];
      logic [SEQ_W-1:0] e;
      fill_order = '{15, 7, 1, 14, 3, 3, 2, 4, 5, 6, 8, 9, 10, 11, 12, 13};
      reset           = 1'b1;
      start           = 1'b0;
      req_seq_no      = '0;
      req_flags       = '0;
      req_payload_ref = '0;
      req_payload_len = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(CSR_SYN_CODE, 8'h00);
      csr_write(CSR_ACK_CODE, 8'hFF);
      csr_write(CSR_SYN_ACK_CODE, 8'hA5);
      csr_write(CSR_FIN_MASK, 8'h00);
      csr_write(CSR_NO_REG, 8'h5A);

      // handshake
      send_request('0, link.syn_code, '1, '1);
      send_request(32'd1, link.ack_code, '0, '0);

      // old, too far ahead, window edge, in-order with over-long payload
      send_request('0, 8'hFF, '1, '1);
      send_request('1, 8'h00, '0, '0);
      send_request(link.exp_seq + WINDOW, 8'h00, 16'h1234, 11'd10);
      send_request(link.exp_seq, 8'h00, '1, '1);

      // fill the whole window out of order, including a repeat, then release it
      e = link.exp_seq;
      foreach (fill_order[i])
         send_request(e + fill_order[i], FLG_W'($urandom_range(0, 255)),
                      REF_W'($urandom_range(0, 65535)),
                      LEN_W'($urandom_range(0, PAYLOAD_MAX)));
      send_request(e, 8'hFF, 16'h0000, LEN_W'(PAYLOAD_MAX));

      wait_idle();
      csr_write(CSR_ACK_CODE, 8'h00);
      csr_write(CSR_SYN_CODE, 8'hFF);
      repeat (135) send_random(8'hFF);

      wait_idle();
      csr_write(CSR_FIN_MASK, 8'h80);
      csr_write(CSR_SYN_ACK_CODE, 8'hFF);
      csr_write(CSR_ACK_CODE, FLG_W'($urandom_range(0, 255)));
      repeat (146) send_random(8'h7F);

      // close the link with a FIN released out of order
      wait_idle();
      csr_write(CSR_FIN_MASK, 8'hFF);
      csr_write(CSR_ACK_CODE, 8'h5C);
      e = link.exp_seq;
      send_request(e + 2, FIN_FLAG, 16'hBEEF, 11'd64);
      send_request(e + 1, 8'h00, 16'h0F0F, 11'd1);
      send_request(e + 5, 8'h00, 16'hF0F0, 11'd2);
      send_request(e, 8'h00, 16'h5555, 11'd3);
      while (link.phase != PH_CLOSED)
         send_request(link.exp_seq, FIN_FLAG, REF_W'($urandom_range(0, 65535)), 11'd5);

      // closed link ignores everything
      send_request(link.exp_seq, 8'h00, 16'h1111, 11'd7);
      send_request('0, 8'h00, 16'h2222, 11'd8);
      wait_idle();

      if (link.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sliding_window_reorder_receiver_top.f
rtl/swrr_pkg.sv
rtl/swrr_alu.sv
rtl/swrr_slots.sv
rtl/sliding_window_reorder_receiver_top.sv
sim/tb_sliding_window_reorder_receiver_top.sv
